>>> src/lrudir_pkg.sv
// lrudir_pkg: shared types and codes for the lru item cache directory
// used by lrudir_ctrl, lrudir_dp and lru_item_cache_directory; no dependencies
`timescale 1ns / 1ps

package lrudir_pkg;

  localparam int INDEX_BITS = 16;
  localparam int COUNT_BITS = 17;
  localparam int SLOT_BITS  = 4;

  // operation codes
  localparam logic [1:0] OP_IMAGE    = 2'd0;
  localparam logic [1:0] OP_ENCODED  = 2'd1;
  localparam logic [1:0] OP_FLUSH    = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_REJECTED = 2'd0;
  localparam logic [1:0] STAT_CACHED   = 2'd1;
  localparam logic [1:0] STAT_LOAD     = 2'd2;
  localparam logic [1:0] STAT_FLUSHED  = 2'd3;

  typedef struct packed {
    logic [1:0]            operation;
    logic [INDEX_BITS-1:0] item_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [SLOT_BITS-1:0]  slot;
    logic                  evicted;
    logic [INDEX_BITS-1:0] evicted_index;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_UPDATE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic flush;
    logic reject;
    logic begin_scan;
    logic scan_read;
    logic update;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_flush;
    logic access_ok;
    logic scan_last;
  } dp_status_t;

endpackage

>>> src/lrudir_ram.sv
// lrudir_ram: generic two port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module lrudir_ram #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/lrudir_ctrl.sv
// lrudir_ctrl: sequencer for the directory; decodes a transaction and runs the slot scan
// depends on lrudir_pkg
`timescale 1ns / 1ps

module lrudir_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  lrudir_pkg::dp_status_t status,
  output lrudir_pkg::ctl_cmd_t   cmd
);

  import lrudir_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && status.access_ok) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (status.is_flush) begin
            cmd.flush = 1'b1;
          end else if (status.access_ok) begin
            cmd.begin_scan = 1'b1;
          end else begin
            cmd.reject = 1'b1;
          end
        end
      end
      ST_SCAN:   cmd.scan_read = 1'b1;
      ST_LAST:   cmd = '0;
      ST_UPDATE: cmd.update = 1'b1;
      default:   cmd = '0;
    endcase
  end

endmodule

>>> src/lrudir_dp.sv
// lrudir_dp: slot store, valid bits, scan trackers, use clock and result register
// depends on lrudir_pkg and lrudir_ram
`timescale 1ns / 1ps

module lrudir_dp #(
  parameter int NUM_SLOTS  = 16,
  parameter int STAMP_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lrudir_pkg::in_item_t                item,
  input  logic                                cfg_valid,
  input  logic [lrudir_pkg::COUNT_BITS-1:0]   cfg_data,
  input  lrudir_pkg::ctl_cmd_t                cmd,
  output lrudir_pkg::dp_status_t              status,
  output logic                                done,
  output lrudir_pkg::result_t                 result
);

  import lrudir_pkg::*;

  localparam int IDX_W   = $clog2(NUM_SLOTS);
  localparam int ENTRY_W = INDEX_BITS + STAMP_BITS + 2;

  // entry layout: key, stamp, image tried, encoded tried
  localparam int KEY_LSB   = STAMP_BITS + 2;
  localparam int STAMP_LSB = 2;

  logic [COUNT_BITS-1:0] item_count;
  logic [NUM_SLOTS-1:0]  slot_valid;
  logic [STAMP_BITS-1:0] use_clock;

  logic [1:0]            op;
  logic [INDEX_BITS-1:0] key;

  logic [IDX_W-1:0]      addr;
  logic                  rd_pend;
  logic [IDX_W-1:0]      rd_idx;
  logic [ENTRY_W-1:0]    rd_data;

  logic                  hit_found;
  logic [IDX_W-1:0]      hit_idx;
  logic                  hit_img;
  logic                  hit_enc;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic                  min_seen;
  logic [STAMP_BITS-1:0] min_stamp;
  logic [IDX_W-1:0]      min_idx;
  logic [INDEX_BITS-1:0] min_key;

  logic [INDEX_BITS-1:0] e_key;
  logic [STAMP_BITS-1:0] e_stamp;
  logic                  e_valid;

  logic [IDX_W-1:0]      target;
  logic                  evict;
  logic                  img_old;
  logic                  enc_old;
  logic                  img_new;
  logic                  enc_new;
  logic                  tried;
  logic [STAMP_BITS-1:0] clock_next;
  logic [ENTRY_W-1:0]    wr_data;

  assign e_key   = rd_data[KEY_LSB +: INDEX_BITS];
  assign e_stamp = rd_data[STAMP_LSB +: STAMP_BITS];
  assign e_valid = slot_valid[rd_idx];

  assign status.is_flush  = (item.operation == OP_FLUSH);
  assign status.access_ok = ((item.operation == OP_IMAGE) || (item.operation == OP_ENCODED))
                            && ({1'b0, item.item_index} < item_count);
  assign status.scan_last = (addr == IDX_W'(NUM_SLOTS - 1));

  // update of the chosen slot
  always_comb begin
    evict = 1'b0;
    if (hit_found) begin
      target = hit_idx;
    end else if (free_found) begin
      target = free_idx;
    end else begin
      target = min_idx;
      evict  = 1'b1;
    end
    img_old    = hit_found & hit_img;
    enc_old    = hit_found & hit_enc;
    tried      = (op == OP_IMAGE) ? img_old : enc_old;
    img_new    = img_old | (op == OP_IMAGE);
    enc_new    = enc_old | (op != OP_IMAGE);
    clock_next = use_clock + 1'b1;
    wr_data    = {key, clock_next, img_new, enc_new};
  end

  lrudir_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_slots (
    .clk     (clk),
    .wr_en   (cmd.update),
    .wr_addr (target),
    .wr_data (wr_data),
    .rd_en   (cmd.scan_read),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
      slot_valid <= '0;
      use_clock  <= '0;
      rd_pend    <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        item_count <= cfg_data;
      end
      if (cmd.flush) begin
        slot_valid <= '0;
      end else if (cmd.update) begin
        slot_valid[target] <= 1'b1;
      end
      if (cmd.update) begin
        use_clock <= clock_next;
      end
      rd_pend <= cmd.scan_read;
      done    <= cmd.flush | cmd.reject | cmd.update;
    end
  end

  // scan and result registers
  always_ff @(posedge clk) begin
    if (cmd.begin_scan) begin
      op         <= item.operation;
      key        <= item.item_index;
      addr       <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      min_seen   <= 1'b0;
    end else begin
      if (cmd.scan_read) begin
        addr   <= addr + 1'b1;
        rd_idx <= addr;
      end
      if (rd_pend) begin
        if (e_valid && !hit_found && (e_key == key)) begin
          hit_found <= 1'b1;
          hit_idx   <= rd_idx;
          hit_img   <= rd_data[1];
          hit_enc   <= rd_data[0];
        end
        if (!e_valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
        if (!min_seen || (e_stamp < min_stamp)) begin
          min_seen  <= 1'b1;
          min_stamp <= e_stamp;
          min_idx   <= rd_idx;
          min_key   <= e_key;
        end
      end
    end

    if (cmd.flush) begin
      result <= '{status: STAT_FLUSHED, slot: '0, evicted: 1'b0, evicted_index: '0};
    end else if (cmd.reject) begin
      result <= '{status: STAT_REJECTED, slot: '0, evicted: 1'b0, evicted_index: '0};
    end else if (cmd.update) begin
      result.status        <= tried ? STAT_CACHED : STAT_LOAD;
      result.slot          <= SLOT_BITS'(target);
      result.evicted       <= evict;
      result.evicted_index <= evict ? min_key : '0;
    end
  end

endmodule

>>> src/lru_item_cache_directory.sv
// lru_item_cache_directory: top level of the lru item cache directory
// depends on lrudir_pkg, lrudir_ctrl, lrudir_dp and lrudir_ram
`timescale 1ns / 1ps

// usage
// - request channel: drive item and raise start; the transaction is taken at a
//   rising edge with start high and busy low
// - result channel: done is high for exactly one cycle with result valid; the
//   receiver cannot stall, so it must take the result in that cycle
// - config channel: cfg_data is written to item_count when cfg_valid and
//   cfg_ready are both high; cfg_ready is always high; write only while idle
// - flush and rejected transactions: result and done are registered at the edge
//   that accepts them and busy stays low, so a new one can follow at once
// - an image or encoded access reads every slot of the slot ram once, one
//   address per cycle, in ST_SCAN, then passes ST_LAST and ST_UPDATE; the
//   result is registered as ST_UPDATE ends and the next one can be taken then
// - reset: all slots invalid, use clock zero, item_count zero, so every access
//   is rejected until item_count is written; slot ram contents need no clearing
module lru_item_cache_directory #(
  parameter int NUM_SLOTS  = 16,
  parameter int STAMP_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  lrudir_pkg::in_item_t              item,
  output logic                              done,
  output lrudir_pkg::result_t               result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lrudir_pkg::COUNT_BITS-1:0] cfg_data
);

  import lrudir_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  // config register is always writable
  assign cfg_ready = 1'b1;

  // sequencer: decode, scan over the slots, update
  lrudir_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // slot store, lru trackers, use clock and result register
  lrudir_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .done      (done),
    .result    (result)
  );

endmodule
